>>> sv/tfn_pkg.sv
// shared types and constants for the triangle face normal block
// no dependencies
package tfn_pkg;

  localparam int CoordW    = 16;
  localparam int EdgeW     = CoordW + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int MagW      = ProdW;
  localparam int MsbW      = 6;
  localparam int NormW     = 30;
  localparam int SqW       = 2 * NormW;
  localparam int SumW      = SqW + 2;
  localparam int RootAccW  = 64;
  localparam int RootSteps = 32;
  localparam int LenW      = 32;
  localparam int QuotW     = 15;
  localparam int RemW      = LenW + 1;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;
  localparam logic [QuotW-1:0] QuotMax = 15'd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
    logic signed [CoordW-1:0] p3_x;
    logic signed [CoordW-1:0] p3_y;
    logic signed [CoordW-1:0] p3_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] norm_x;
    logic signed [CoordW-1:0] norm_y;
    logic signed [CoordW-1:0] norm_z;
    logic                     degenerate;
  } tfn_out_t;

  // cross product as sign and magnitude, plus zero-vector flag
  typedef struct packed {
    logic [2:0]      neg;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic [MagW-1:0] mag_z;
    logic            degenerate;
  } tfn_cls_t;

endpackage

>>> sv/tfn_front.sv
// front end: edge vectors, cross product, sign/magnitude split
// depends on tfn_pkg
module tfn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfn_pkg::tfn_in_t  in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output tfn_pkg::tfn_cls_t cls_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic signed [tfn_pkg::EdgeW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [tfn_pkg::ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [tfn_pkg::ProdW-1:0] cx, cy, cz;
  tfn_pkg::tfn_cls_t cls_d, cls_q;

  assign en3 = !v3_q || !full_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;
  assign push_o = v3_q && !full_i;
  assign cls_o = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ax_q <= {in_data_i.p2_x[15], in_data_i.p2_x} - {in_data_i.p1_x[15], in_data_i.p1_x};
      ay_q <= {in_data_i.p2_y[15], in_data_i.p2_y} - {in_data_i.p1_y[15], in_data_i.p1_y};
      az_q <= {in_data_i.p2_z[15], in_data_i.p2_z} - {in_data_i.p1_z[15], in_data_i.p1_z};
      bx_q <= {in_data_i.p3_x[15], in_data_i.p3_x} - {in_data_i.p1_x[15], in_data_i.p1_x};
      by_q <= {in_data_i.p3_y[15], in_data_i.p3_y} - {in_data_i.p1_y[15], in_data_i.p1_y};
      bz_q <= {in_data_i.p3_z[15], in_data_i.p3_z} - {in_data_i.p1_z[15], in_data_i.p1_z};
    end
    if (en2) begin
      p0_q <= ay_q * bz_q;
      p1_q <= az_q * by_q;
      p2_q <= az_q * bx_q;
      p3_q <= ax_q * bz_q;
      p4_q <= ax_q * by_q;
      p5_q <= ay_q * bx_q;
    end
    if (en3) cls_q <= cls_d;
  end

  always_comb begin
    cx = p0_q - p1_q;
    cy = p2_q - p3_q;
    cz = p4_q - p5_q;
    cls_d.neg   = {cx[tfn_pkg::ProdW-1], cy[tfn_pkg::ProdW-1], cz[tfn_pkg::ProdW-1]};
    cls_d.mag_x = cx[tfn_pkg::ProdW-1] ? tfn_pkg::MagW'(-cx) : tfn_pkg::MagW'(cx);
    cls_d.mag_y = cy[tfn_pkg::ProdW-1] ? tfn_pkg::MagW'(-cy) : tfn_pkg::MagW'(cy);
    cls_d.mag_z = cz[tfn_pkg::ProdW-1] ? tfn_pkg::MagW'(-cz) : tfn_pkg::MagW'(cz);
    cls_d.degenerate = (cx == '0) && (cy == '0) && (cz == '0);
  end

endmodule

>>> sv/tfn_queue.sv
// short queue between front and back
// depends on tfn_pkg
module tfn_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tfn_pkg::tfn_cls_t data_i,
  input  logic              pop_i,
  output tfn_pkg::tfn_cls_t data_o,
  output logic              full_o,
  output logic              empty_o
);

  tfn_pkg::tfn_cls_t mem_q [tfn_pkg::QueueDepth];
  logic [tfn_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [tfn_pkg::QueueCntW-1:0] cnt_q;

  assign full_o  = cnt_q == tfn_pkg::QueueCntW'(tfn_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> sv/tfn_back.sv
// back end: normalize, squared length, square root, per-lane divide
// depends on tfn_pkg
module tfn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tfn_pkg::tfn_cls_t cls_i,
  output logic              valid_o,
  output tfn_pkg::tfn_out_t res_o
);

  localparam int Rs = tfn_pkg::RootSteps;
  localparam int Qw = tfn_pkg::QuotW;

  typedef struct packed {
    logic [2:0]                  neg;
    logic                        degenerate;
    logic [tfn_pkg::NormW-1:0]   u_x;
    logic [tfn_pkg::NormW-1:0]   u_y;
    logic [tfn_pkg::NormW-1:0]   u_z;
  } tfn_side_t;

  // normalize stages
  logic                      va_q, vb_q, vc_q;
  tfn_pkg::tfn_cls_t         cls_a_q;
  logic [tfn_pkg::MsbW-1:0]  msb, msb_q;
  logic [tfn_pkg::MagW-1:0]  orv;
  logic [tfn_pkg::MagW-1:0]  shx, shy, shz;
  tfn_side_t                 side_b_q, side_c_q;
  logic [tfn_pkg::SqW-1:0]   sqx_q, sqy_q, sqz_q;

  // root stages
  logic                         rv_q   [Rs+1];
  logic [tfn_pkg::RootAccW-1:0] rn_q   [Rs+1];
  logic [tfn_pkg::RootAccW-1:0] rr_q   [Rs+1];
  tfn_side_t                    rs_q   [Rs+1];

  // divide stages
  logic                      dv_q   [Qw+1];
  logic [tfn_pkg::RemW-1:0]  dd_q   [Qw+1];
  logic [Qw-1:0]             dl_q   [Qw+1];
  logic [tfn_pkg::RemW-1:0]  dr_q   [Qw+1][3];
  logic [Qw-1:0]             dq_q   [Qw+1][3];
  logic [2:0]                dn_q   [Qw+1];
  logic                      dg_q   [Qw+1];

  logic [tfn_pkg::LenW-1:0]  len;

  always_comb begin
    orv = cls_i.mag_x | cls_i.mag_y | cls_i.mag_z;
    msb = '0;
    for (int i = 0; i < tfn_pkg::MagW; i++) begin
      if (orv[i]) msb = tfn_pkg::MsbW'(i);
    end
  end

  always_comb begin
    if (msb_q >= 6'd30) begin
      shx = cls_a_q.mag_x >> (msb_q - 6'd29);
      shy = cls_a_q.mag_y >> (msb_q - 6'd29);
      shz = cls_a_q.mag_z >> (msb_q - 6'd29);
    end else begin
      shx = cls_a_q.mag_x << (6'd29 - msb_q);
      shy = cls_a_q.mag_y << (6'd29 - msb_q);
      shz = cls_a_q.mag_z << (6'd29 - msb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      rv_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      rv_q[0] <= vc_q;
    end
  end

  // msb_q is aligned with cls_a_q: both register from the same item
  logic [tfn_pkg::MsbW-1:0] msb_a_q;
  assign msb_q = msb_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_a_q  <= cls_i;
      msb_a_q  <= msb;
      side_b_q.neg        <= cls_a_q.neg;
      side_b_q.degenerate <= cls_a_q.degenerate;
      side_b_q.u_x        <= shx[tfn_pkg::NormW-1:0];
      side_b_q.u_y        <= shy[tfn_pkg::NormW-1:0];
      side_b_q.u_z        <= shz[tfn_pkg::NormW-1:0];
      sqx_q    <= side_b_q.u_x * side_b_q.u_x;
      sqy_q    <= side_b_q.u_y * side_b_q.u_y;
      sqz_q    <= side_b_q.u_z * side_b_q.u_z;
      side_c_q <= side_b_q;
      rn_q[0]  <= tfn_pkg::RootAccW'(tfn_pkg::SumW'(sqx_q) + tfn_pkg::SumW'(sqy_q)
                  + tfn_pkg::SumW'(sqz_q));
      rr_q[0]  <= '0;
      rs_q[0]  <= side_c_q;
    end
  end

  for (genvar k = 0; k < Rs; k++) begin : g_root
    localparam logic [tfn_pkg::RootAccW-1:0] Bit = 64'd1 << (62 - 2 * k);
    logic [tfn_pkg::RootAccW-1:0] sum;
    assign sum = rr_q[k] + Bit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rv_q[k+1] <= rv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q[k+1] <= rs_q[k];
        if (rn_q[k] >= sum) begin
          rn_q[k+1] <= rn_q[k] - sum;
          rr_q[k+1] <= (rr_q[k] >> 1) + Bit;
        end else begin
          rn_q[k+1] <= rn_q[k];
          rr_q[k+1] <= rr_q[k] >> 1;
        end
      end
    end
  end

  assign len = rr_q[Rs][tfn_pkg::LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= rv_q[Rs];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q[0] <= {len, 1'b0};
      dl_q[0] <= len[Qw-1:0];
      dn_q[0] <= rs_q[Rs].neg;
      dg_q[0] <= rs_q[Rs].degenerate;
      dr_q[0][0] <= tfn_pkg::RemW'(rs_q[Rs].u_x) + tfn_pkg::RemW'(len[tfn_pkg::LenW-1:Qw]);
      dr_q[0][1] <= tfn_pkg::RemW'(rs_q[Rs].u_y) + tfn_pkg::RemW'(len[tfn_pkg::LenW-1:Qw]);
      dr_q[0][2] <= tfn_pkg::RemW'(rs_q[Rs].u_z) + tfn_pkg::RemW'(len[tfn_pkg::LenW-1:Qw]);
      dq_q[0][0] <= '0;
      dq_q[0][1] <= '0;
      dq_q[0][2] <= '0;
    end
  end

  for (genvar j = 0; j < Qw; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dd_q[j+1] <= dd_q[j];
        dl_q[j+1] <= dl_q[j];
        dn_q[j+1] <= dn_q[j];
        dg_q[j+1] <= dg_q[j];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [tfn_pkg::RemW:0] rsh;
      logic                   ge;
      assign rsh = {dr_q[j][l], dl_q[j][Qw-1-j]};
      assign ge  = rsh >= {1'b0, dd_q[j]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dr_q[j+1][l] <= ge ? tfn_pkg::RemW'(rsh - {1'b0, dd_q[j]})
                             : tfn_pkg::RemW'(rsh);
          dq_q[j+1][l] <= {dq_q[j][l][Qw-2:0], ge};
        end
      end
    end
  end

  function automatic logic [15:0] fin(input logic [Qw-1:0] q, input logic neg,
                                      input logic deg);
    logic [Qw-1:0] c;
    logic [15:0]   w;
    c = (q > tfn_pkg::QuotMax) ? tfn_pkg::QuotMax : q;
    w = {1'b0, c};
    if (deg) w = '0;
    else if (neg) w = 16'(-w);
    return w;
  endfunction

  assign valid_o           = dv_q[Qw];
  assign res_o.norm_x      = fin(dq_q[Qw][0], dn_q[Qw][2], dg_q[Qw]);
  assign res_o.norm_y      = fin(dq_q[Qw][1], dn_q[Qw][1], dg_q[Qw]);
  assign res_o.norm_z      = fin(dq_q[Qw][2], dn_q[Qw][0], dg_q[Qw]);
  assign res_o.degenerate  = dg_q[Qw];

endmodule

>>> sv/triangle_face_normal.sv
// top level: unit normal of a triangle, front end, queue, back end, output register
// depends on tfn_pkg, tfn_front, tfn_queue, tfn_back
//
//  channel  direction  handshake                  word
//  in       input      in_valid_i / in_stall_o    tfn_in_t  (three vertices, Q8.8)
//  out      output     out_valid_o / out_stall_i  tfn_out_t (unit normal Q1.14, flag)
//
// one triangle accepted per cycle unless in_stall_o is high; the back end holds the 32-step root
// pipeline and the 15-step divide pipeline
// rst_ni clears all valid bits and queue pointers
// an output stall freezes the back end; the four-entry queue lets the front keep
// taking words until it fills
module triangle_face_normal (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfn_pkg::tfn_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfn_pkg::tfn_out_t out_data_o
);

  logic              push, pop, full, empty, back_en, res_valid;
  tfn_pkg::tfn_cls_t cls_f, cls_b;
  tfn_pkg::tfn_out_t res;
  logic              out_valid_q;
  tfn_pkg::tfn_out_t out_data_q;

  assign back_en = !(out_valid_q && out_stall_i);
  assign pop     = back_en && !empty;

  tfn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .cls_o      (cls_f)
  );

  tfn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_f),
    .pop_i   (pop),
    .data_o  (cls_b),
    .full_o  (full),
    .empty_o (empty)
  );

  tfn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (pop),
    .cls_i   (cls_b),
    .valid_o (res_valid),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> tb/sv/triangle_face_normal_test.sv
// testbench for triangle_face_normal: drives triangles, predicts unit normals and checks them
// depends on tfn_pkg and triangle_face_normal
module triangle_face_normal_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LatencyWait = 120;
  localparam int WatchLimit  = 20000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  tfn_pkg::tfn_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  tfn_pkg::tfn_out_t out_data_o;

  tfn_pkg::tfn_out_t normal_q[$];
  int       mismatches;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       quiet_cycles;

  triangle_face_normal i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic tfn_pkg::tfn_out_t face_normal(tfn_pkg::tfn_in_t t);
    longint ax, ay, az, bx, by, bz;
    longint c[3];
    longint unsigned u[3];
    longint unsigned m, sq, len, q;
    int sh;
    tfn_pkg::tfn_out_t r;
    ax = longint'(t.p2_x) - longint'(t.p1_x);
    ay = longint'(t.p2_y) - longint'(t.p1_y);
    az = longint'(t.p2_z) - longint'(t.p1_z);
    bx = longint'(t.p3_x) - longint'(t.p1_x);
    by = longint'(t.p3_y) - longint'(t.p1_y);
    bz = longint'(t.p3_z) - longint'(t.p1_z);
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (u[i] > m) m = u[i];
    end
    r = '0;
    if (m == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sh = 0;
    if (m >= 64'h4000_0000) begin
      while ((m >> sh) >= 64'h4000_0000) sh++;
      for (int i = 0; i < 3; i++) u[i] = u[i] >> sh;
    end else begin
      while ((m << sh) < 64'h2000_0000) sh++;
      for (int i = 0; i < 3; i++) u[i] = u[i] << sh;
    end
    sq = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    len = int_sqrt(sq);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((u[i] << 15) + len) / (len << 1);
      if (q > 16384) q = 16384;
      if (c[i] < 0) q = -q;
      if (i == 0) r.norm_x = q[15:0];
      else if (i == 1) r.norm_y = q[15:0];
      else r.norm_z = q[15:0];
    end
    return r;
  endfunction

  task automatic send_triangle(tfn_pkg::tfn_in_t t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    normal_q.push_back(face_normal(t));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (normal_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    tfn_pkg::tfn_in_t t;
    send_triangle('0);
    t = '0; t.p2_x = 16'h0100; t.p3_y = 16'h0100;
    send_triangle(t);
    t = '0; t.p2_y = 16'h0100; t.p3_x = 16'h0100;
    send_triangle(t);
    t = '0; t.p2_x = 16'h0100; t.p3_x = 16'h0200;
    send_triangle(t);
    t = '0; t.p2_x = 16'h0001; t.p3_y = 16'h0001;
    send_triangle(t);
    t = '0; t.p1_x = 16'h8000; t.p1_y = 16'h8000; t.p1_z = 16'h8000;
    t.p2_x = 16'h7fff; t.p3_y = 16'h7fff;
    send_triangle(t);
    t.p3_z = 16'h7fff;
    send_triangle(t);
    t = '1;
    send_triangle(t);
    t = {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
         16'h8000, 16'h7fff, 16'h8000};
    send_triangle(t);
    t = {16'h1234, 16'h8001, 16'h0f0f, 16'h1235, 16'h8001, 16'h0f0f,
         16'h1234, 16'h8002, 16'h0f10};
    send_triangle(t);
    t = {16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'h7fff, 16'h8000,
         16'h0001, 16'h0100, 16'hff00};
    send_triangle(t);
  endtask

  task automatic test_random(int n);
    tfn_pkg::tfn_in_t t;
    for (int k = 0; k < n; k++) begin
      t = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
           pick_coord(), pick_coord(), pick_coord(), pick_coord()};
      if ($urandom_range(9) == 0) begin
        t.p3_x = t.p2_x; t.p3_y = t.p2_y; t.p3_z = t.p2_z;
      end
      send_triangle(t);
      if (k == n / 2) drain_results();
    end
  endtask

  task automatic set_idle(int s, int r);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        tfn_pkg::tfn_out_t e;
        e = normal_q.pop_front();
        if (e !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x %h y %h z %h deg %b, got x %h y %h z %h deg %b",
                     e.norm_x, e.norm_y, e.norm_z, e.degenerate, out_data_o.norm_x,
                     out_data_o.norm_y, out_data_o.norm_z, out_data_o.degenerate);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("triangle_face_normal regression: fail");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    set_idle(0, 0);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_idle(37, 58);
    test_directed();
    test_random(280);
    set_idle(58, 37);
    test_random(280);
    set_idle(0, 0);
    test_random(290);
    drain_results();
    repeat (LatencyWait) @(negedge clk_i);
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("triangle_face_normal regression: pass");
    end else begin
      $display("triangle_face_normal regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tfn_pkg.sv
sv/tfn_front.sv
sv/tfn_queue.sv
sv/tfn_back.sv
sv/triangle_face_normal.sv
tb/sv/triangle_face_normal_test.sv
